/* src/rax_pkg.sv */
// Shared constants, types and step functions for the rotation-axes-to-quaternion block.
// Used by every module under src; depends on nothing.
`default_nettype none

package rax_pkg;

    // Number format
    localparam int FRAC_BITS = 16;
    localparam int FIELD_W   = 18;
    localparam int TR_W      = FIELD_W + 2;          // sum of three fields
    localparam int P_W       = FIELD_W + 1;          // sum or difference of two fields
    localparam int R_W       = 19;                   // clamped radicand, 1 .. below 2^19

    // Square root: s = floor(sqrt(r << FRAC_BITS))
    localparam int N_W       = R_W + FRAC_BITS;
    localparam int SQ_W      = N_W + 1;
    localparam int S_W       = (N_W + 1) / 2;
    localparam int SQ_PER    = 2;                    // root bits per stage
    localparam int SQ_STAGES = S_W / SQ_PER;

    // Reciprocal: k = floor(2^(2*FRAC_BITS-1) / s), s >= 2^(FRAC_BITS/2)
    localparam int K_W       = 24;
    localparam int REM_W     = S_W + 1;
    localparam int RC_PER    = 2;                    // quotient bits per stage
    localparam int RC_STAGES = K_W / RC_PER;
    localparam logic [REM_W-1:0] RC_INIT = REM_W'(1) << (2 * FRAC_BITS - 1 - K_W);

    // Scaling and saturation
    localparam int PROD_W   = P_W + K_W;
    localparam int OUT_MAX  = (1 << (FIELD_W - 1)) - 1;
    localparam int HALF_ONE = 1 << (FRAC_BITS - 1);
    localparam logic signed [TR_W-1:0]    ONE   = TR_W'(1) << FRAC_BITS;
    localparam logic signed [FIELD_W-1:0] Q_MAX = FIELD_W'(OUT_MAX);
    localparam logic signed [FIELD_W-1:0] Q_MIN = ~Q_MAX;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_U     = 2'd1,
        BR_V     = 2'd2,
        BR_T     = 2'd3
    } branch_t;

    // Fields that ride alongside the root and reciprocal
    typedef struct packed {
        logic signed [P_W-1:0] pa;
        logic signed [P_W-1:0] pb;
        logic signed [P_W-1:0] pc;
        branch_t               branch;
        logic                  bad;
    } side_t;

    typedef struct packed {
        side_t          side;
        logic [R_W-1:0] r;
    } fr_t;

    typedef struct packed {
        side_t           side;
        logic [SQ_W-1:0] n;
        logic [SQ_W-1:0] res;
    } sq_t;

    typedef struct packed {
        side_t          side;
        logic [S_W-1:0] s;
    } rs_t;

    typedef struct packed {
        side_t            side;
        logic [S_W-1:0]   s;
        logic [REM_W-1:0] rem;
        logic [K_W-1:0]   q;
    } rc_t;

    typedef struct packed {
        side_t          side;
        logic [S_W-1:0] s;
        logic [K_W-1:0] k;
    } rk_t;

    // One digit of the bit-pair square root; bit weight is 2^sh
    function automatic sq_t sq_step(input sq_t d, input int sh);
        logic [SQ_W-1:0] b;
        logic [SQ_W-1:0] t;
        sq_t             o;
        o = d;
        b = SQ_W'(1) << sh;
        t = d.res + b;
        if (d.n >= t)
        begin
            o.n   = d.n - t;
            o.res = (d.res >> 1) + b;
        end
        else
        begin
            o.res = d.res >> 1;
        end
        return o;
    endfunction

    // One restoring division step; the dividend's low bits are all zero
    function automatic rc_t rc_step(input rc_t d);
        logic [REM_W-1:0] r2;
        rc_t              o;
        o  = d;
        r2 = {d.rem[REM_W-2:0], 1'b0};
        if (r2 >= {1'b0, d.s})
        begin
            o.rem = r2 - {1'b0, d.s};
            o.q   = {d.q[K_W-2:0], 1'b1};
        end
        else
        begin
            o.rem = r2;
            o.q   = {d.q[K_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // Drop fraction bits, apply sign, saturate to the field range
    function automatic logic signed [FIELD_W-1:0] sat_part(input logic neg,
                                                           input logic [PROD_W-1:0] prod);
        logic [PROD_W-1:0]         mag;
        logic signed [FIELD_W-1:0] res;
        mag = prod >> FRAC_BITS;
        if (neg)
        begin
            if (mag > PROD_W'(OUT_MAX + 1))
                res = Q_MIN;
            else
                res = -FIELD_W'(mag);
        end
        else
        begin
            if (mag > PROD_W'(OUT_MAX))
                res = Q_MAX;
            else
                res = FIELD_W'(mag);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* src/rax_select.sv */
// Front stage: trace test, branch choice, radicand clamp and off-diagonal pairs.
// Uses rax_pkg; one register stage.
`default_nettype none

module rax_select (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               src_valid,
    output logic                                    src_stall,
    input  wire logic signed [rax_pkg::FIELD_W-1:0] u_x,
    input  wire logic signed [rax_pkg::FIELD_W-1:0] u_y,
    input  wire logic signed [rax_pkg::FIELD_W-1:0] u_z,
    input  wire logic signed [rax_pkg::FIELD_W-1:0] v_x,
    input  wire logic signed [rax_pkg::FIELD_W-1:0] v_y,
    input  wire logic signed [rax_pkg::FIELD_W-1:0] v_z,
    input  wire logic signed [rax_pkg::FIELD_W-1:0] t_x,
    input  wire logic signed [rax_pkg::FIELD_W-1:0] t_y,
    input  wire logic signed [rax_pkg::FIELD_W-1:0] t_z,
    output logic                                    dst_valid,
    input  wire logic                               dst_stall,
    output rax_pkg::fr_t                            dst_data
);

    logic signed [rax_pkg::TR_W-1:0] dux, dvy, dtz, tr, r_full;
    rax_pkg::fr_t                    data_next;
    rax_pkg::fr_t                    data_reg;
    logic                            valid_reg;
    logic                            ready;

    assign dux = rax_pkg::TR_W'(u_x);
    assign dvy = rax_pkg::TR_W'(v_y);
    assign dtz = rax_pkg::TR_W'(t_z);
    assign tr  = dux + dvy + dtz;

    // Branch choice; ties go to u, then v
    always_comb
    begin
        data_next = '0;
        if (!tr[rax_pkg::TR_W-1])
        begin
            data_next.side.branch = rax_pkg::BR_TRACE;
            r_full                = tr + rax_pkg::ONE;
            data_next.side.pa     = rax_pkg::P_W'(v_z) - rax_pkg::P_W'(t_y);
            data_next.side.pb     = rax_pkg::P_W'(t_x) - rax_pkg::P_W'(u_z);
            data_next.side.pc     = rax_pkg::P_W'(u_y) - rax_pkg::P_W'(v_x);
        end
        else if (dux >= dvy && dux >= dtz)
        begin
            data_next.side.branch = rax_pkg::BR_U;
            r_full                = rax_pkg::ONE + dux - dvy - dtz;
            data_next.side.pa     = rax_pkg::P_W'(u_y) + rax_pkg::P_W'(v_x);
            data_next.side.pb     = rax_pkg::P_W'(t_x) + rax_pkg::P_W'(u_z);
            data_next.side.pc     = rax_pkg::P_W'(v_z) - rax_pkg::P_W'(t_y);
        end
        else if (dvy >= dtz)
        begin
            data_next.side.branch = rax_pkg::BR_V;
            r_full                = rax_pkg::ONE + dvy - dtz - dux;
            data_next.side.pa     = rax_pkg::P_W'(v_z) + rax_pkg::P_W'(t_y);
            data_next.side.pb     = rax_pkg::P_W'(u_y) + rax_pkg::P_W'(v_x);
            data_next.side.pc     = rax_pkg::P_W'(t_x) - rax_pkg::P_W'(u_z);
        end
        else
        begin
            data_next.side.branch = rax_pkg::BR_T;
            r_full                = rax_pkg::ONE + dtz - dux - dvy;
            data_next.side.pa     = rax_pkg::P_W'(t_x) + rax_pkg::P_W'(u_z);
            data_next.side.pb     = rax_pkg::P_W'(v_z) + rax_pkg::P_W'(t_y);
            data_next.side.pc     = rax_pkg::P_W'(u_y) - rax_pkg::P_W'(v_x);
        end
        // Non-positive radicand: clamp to one LSB and flag
        if (r_full[rax_pkg::TR_W-1] || r_full == '0)
        begin
            data_next.side.bad = 1'b1;
            data_next.r        = rax_pkg::R_W'(1);
        end
        else
        begin
            data_next.side.bad = 1'b0;
            data_next.r        = r_full[rax_pkg::R_W-1:0];
        end
    end

    assign ready     = !valid_reg || !dst_stall;
    assign src_stall = !ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready)
            valid_reg <= src_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ready)
            data_reg <= data_next;
    end

    assign dst_valid = valid_reg;
    assign dst_data  = data_reg;

endmodule

`default_nettype wire

/* src/rax_sqrt.sv */
// Pipelined bit-pair square root, two root bits per stage, side fields carried along.
// Uses rax_pkg.
`default_nettype none

module rax_sqrt (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         src_valid,
    output logic              src_stall,
    input  rax_pkg::fr_t      src_data,
    output logic              dst_valid,
    input  wire logic         dst_stall,
    output rax_pkg::rs_t      dst_data
);

    localparam int NS = rax_pkg::SQ_STAGES;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_in;
    logic [NS:0]   ready;
    rax_pkg::sq_t  stage_in  [NS];
    rax_pkg::sq_t  data_next [NS];
    rax_pkg::sq_t  data_reg  [NS];

    // Stage moves when empty or when the next one moves
    always_comb
    begin
        ready[NS] = !dst_stall;
        for (int i = NS - 1; i >= 0; i--)
            ready[i] = !valid_reg[i] || ready[i+1];
    end

    always_comb
    begin
        stage_in[0].side = src_data.side;
        stage_in[0].n    = rax_pkg::SQ_W'(src_data.r) << rax_pkg::FRAC_BITS;
        stage_in[0].res  = '0;
        valid_in[0]      = src_valid;
        for (int i = 1; i < NS; i++)
        begin
            stage_in[i] = data_reg[i-1];
            valid_in[i] = valid_reg[i-1];
        end
    end

    // Root digits, most significant first
    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            data_next[i] = stage_in[i];
            for (int p = 0; p < rax_pkg::SQ_PER; p++)
                data_next[i] = rax_pkg::sq_step(data_next[i],
                    2 * (rax_pkg::S_W - 1 - (i * rax_pkg::SQ_PER + p)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            for (int i = 0; i < NS; i++)
                if (ready[i])
                    valid_reg[i] <= valid_in[i];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NS; i++)
            if (ready[i])
                data_reg[i] <= data_next[i];
    end

    assign src_stall     = !ready[0];
    assign dst_valid     = valid_reg[NS-1];
    assign dst_data.side = data_reg[NS-1].side;
    assign dst_data.s    = data_reg[NS-1].res[rax_pkg::S_W-1:0];

endmodule

`default_nettype wire

/* src/rax_recip.sv */
// Pipelined restoring divider for k = 2^(2F-1) / s, two quotient bits per stage.
// Uses rax_pkg.
`default_nettype none

module rax_recip (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         src_valid,
    output logic              src_stall,
    input  rax_pkg::rs_t      src_data,
    output logic              dst_valid,
    input  wire logic         dst_stall,
    output rax_pkg::rk_t      dst_data
);

    localparam int NS = rax_pkg::RC_STAGES;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_in;
    logic [NS:0]   ready;
    rax_pkg::rc_t  stage_in  [NS];
    rax_pkg::rc_t  data_next [NS];
    rax_pkg::rc_t  data_reg  [NS];

    always_comb
    begin
        ready[NS] = !dst_stall;
        for (int i = NS - 1; i >= 0; i--)
            ready[i] = !valid_reg[i] || ready[i+1];
    end

    // Upper dividend bits are already below s, so the quotient starts at bit K_W-1
    always_comb
    begin
        stage_in[0].side = src_data.side;
        stage_in[0].s    = src_data.s;
        stage_in[0].rem  = rax_pkg::RC_INIT;
        stage_in[0].q    = '0;
        valid_in[0]      = src_valid;
        for (int i = 1; i < NS; i++)
        begin
            stage_in[i] = data_reg[i-1];
            valid_in[i] = valid_reg[i-1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            data_next[i] = stage_in[i];
            for (int p = 0; p < rax_pkg::RC_PER; p++)
                data_next[i] = rax_pkg::rc_step(data_next[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            for (int i = 0; i < NS; i++)
                if (ready[i])
                    valid_reg[i] <= valid_in[i];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NS; i++)
            if (ready[i])
                data_reg[i] <= data_next[i];
    end

    assign src_stall     = !ready[0];
    assign dst_valid     = valid_reg[NS-1];
    assign dst_data.side = data_reg[NS-1].side;
    assign dst_data.s    = data_reg[NS-1].s;
    assign dst_data.k    = data_reg[NS-1].q;

endmodule

`default_nettype wire

/* src/rax_scale.sv */
// Pair scaling by k, saturation and routing of the parts to w, x, y, z.
// Uses rax_pkg; a multiply stage and the output register stage.
`default_nettype none

module rax_scale (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          src_valid,
    output logic                               src_stall,
    input  rax_pkg::rk_t                       src_data,
    output logic                               dst_valid,
    input  wire logic                          dst_stall,
    output logic signed [rax_pkg::FIELD_W-1:0] quat_w,
    output logic signed [rax_pkg::FIELD_W-1:0] quat_x,
    output logic signed [rax_pkg::FIELD_W-1:0] quat_y,
    output logic signed [rax_pkg::FIELD_W-1:0] quat_z,
    output logic [1:0]                         branch_taken,
    output logic                               bad_input
);

    typedef struct packed {
        logic [2:0]                     neg;
        logic [rax_pkg::PROD_W-1:0]     pra;
        logic [rax_pkg::PROD_W-1:0]     prb;
        logic [rax_pkg::PROD_W-1:0]     prc;
        logic [rax_pkg::S_W-2:0]        main;
        rax_pkg::branch_t               branch;
        logic                           bad;
    } ml_t;

    logic [rax_pkg::P_W-1:0]           mag_a, mag_b, mag_c;
    logic [rax_pkg::PROD_W-1:0]        kx;
    ml_t                               ml_next, ml_reg;
    logic                              ml_valid_reg, out_valid_reg;
    logic                              ready_ml, ready_out;
    logic signed [rax_pkg::FIELD_W-1:0] part_a, part_b, part_c, part_m;
    logic signed [rax_pkg::FIELD_W-1:0] w_next, x_next, y_next, z_next;
    logic signed [rax_pkg::FIELD_W-1:0] w_reg, x_reg, y_reg, z_reg;
    rax_pkg::branch_t                  branch_reg;
    logic                              bad_reg;

    assign ready_out = !out_valid_reg || !dst_stall;
    assign ready_ml  = !ml_valid_reg || ready_out;
    assign src_stall = !ready_ml;

    // Magnitudes times k
    assign mag_a = src_data.side.pa[rax_pkg::P_W-1] ? -src_data.side.pa : src_data.side.pa;
    assign mag_b = src_data.side.pb[rax_pkg::P_W-1] ? -src_data.side.pb : src_data.side.pb;
    assign mag_c = src_data.side.pc[rax_pkg::P_W-1] ? -src_data.side.pc : src_data.side.pc;
    assign kx    = rax_pkg::PROD_W'(src_data.k);

    always_comb
    begin
        ml_next.neg    = {src_data.side.pa[rax_pkg::P_W-1],
                          src_data.side.pb[rax_pkg::P_W-1],
                          src_data.side.pc[rax_pkg::P_W-1]};
        ml_next.pra    = rax_pkg::PROD_W'(mag_a) * kx;
        ml_next.prb    = rax_pkg::PROD_W'(mag_b) * kx;
        ml_next.prc    = rax_pkg::PROD_W'(mag_c) * kx;
        ml_next.main   = src_data.s[rax_pkg::S_W-1:1];
        ml_next.branch = src_data.side.branch;
        ml_next.bad    = src_data.side.bad;
    end

    // Saturate and route by branch
    assign part_a = rax_pkg::sat_part(ml_reg.neg[2], ml_reg.pra);
    assign part_b = rax_pkg::sat_part(ml_reg.neg[1], ml_reg.prb);
    assign part_c = rax_pkg::sat_part(ml_reg.neg[0], ml_reg.prc);
    assign part_m = rax_pkg::FIELD_W'(ml_reg.main);

    always_comb
    begin
        case (ml_reg.branch)
            rax_pkg::BR_TRACE:
            begin
                w_next = part_m; x_next = part_a; y_next = part_b; z_next = part_c;
            end
            rax_pkg::BR_U:
            begin
                x_next = part_m; y_next = part_a; z_next = part_b; w_next = part_c;
            end
            rax_pkg::BR_V:
            begin
                y_next = part_m; z_next = part_a; x_next = part_b; w_next = part_c;
            end
            default:
            begin
                z_next = part_m; x_next = part_a; y_next = part_b; w_next = part_c;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ml_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready_ml)
                ml_valid_reg <= src_valid;
            if (ready_out)
                out_valid_reg <= ml_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_ml)
            ml_reg <= ml_next;
        if (ready_out)
        begin
            w_reg      <= w_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            z_reg      <= z_next;
            branch_reg <= ml_reg.branch;
            bad_reg    <= ml_reg.bad;
        end
    end

    assign dst_valid    = out_valid_reg;
    assign quat_w       = w_reg;
    assign quat_x       = x_reg;
    assign quat_y       = y_reg;
    assign quat_z       = z_reg;
    assign branch_taken = branch_reg;
    assign bad_input    = bad_reg;

endmodule

`default_nettype wire

/* src/rotation_axes_to_quaternion.sv */
// Top level: rotation axes (u, v, t) to unit quaternion, fully pipelined.
// Uses rax_pkg, rax_select, rax_sqrt, rax_recip, rax_scale.
//
// Usage
//   Input channel axes_valid / axes_stall carries the nine Q2.16 axis components.
//   Output channel quat_valid / quat_stall carries quat_w..quat_z (Q2.16, saturated),
//   branch_taken and bad_input. An item moves when valid is high and stall is low.
//   The path runs through 1 selection stage, 9 square-root stages (2 root
//   bits each), 12 reciprocal stages (2 quotient bits each), a multiply stage
//   and the output register. Throughput is one item per cycle while nothing
//   stalls; the root and divider pipeline holds 21 of the stages, and every
//   stage is a register so an item can enter each cycle.
//   Each stage holds its own valid bit and fills whenever it is empty, so holes
//   close up while quat_stall is high and axes_stall rises only when every stage
//   is full. A held result keeps its fields steady until taken.
//   Reset (rst_n low, asynchronous) empties the pipeline; there is no other state
//   and no configuration.
`default_nettype none

module rotation_axes_to_quaternion (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                axes_valid,
    output logic                                     axes_stall,
    input  wire logic signed [rax_pkg::FIELD_W-1:0]  u_x,
    input  wire logic signed [rax_pkg::FIELD_W-1:0]  u_y,
    input  wire logic signed [rax_pkg::FIELD_W-1:0]  u_z,
    input  wire logic signed [rax_pkg::FIELD_W-1:0]  v_x,
    input  wire logic signed [rax_pkg::FIELD_W-1:0]  v_y,
    input  wire logic signed [rax_pkg::FIELD_W-1:0]  v_z,
    input  wire logic signed [rax_pkg::FIELD_W-1:0]  t_x,
    input  wire logic signed [rax_pkg::FIELD_W-1:0]  t_y,
    input  wire logic signed [rax_pkg::FIELD_W-1:0]  t_z,
    output logic                                     quat_valid,
    input  wire logic                                quat_stall,
    output logic signed [rax_pkg::FIELD_W-1:0]       quat_w,
    output logic signed [rax_pkg::FIELD_W-1:0]       quat_x,
    output logic signed [rax_pkg::FIELD_W-1:0]       quat_y,
    output logic signed [rax_pkg::FIELD_W-1:0]       quat_z,
    output logic [1:0]                               branch_taken,
    output logic                                     bad_input
);

    logic         sel_valid, sel_stall;
    rax_pkg::fr_t sel_data;
    logic         sq_valid, sq_stall;
    rax_pkg::rs_t sq_data;
    logic         rc_valid, rc_stall;
    rax_pkg::rk_t rc_data;

    rax_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (axes_valid),
        .src_stall (axes_stall),
        .u_x       (u_x),
        .u_y       (u_y),
        .u_z       (u_z),
        .v_x       (v_x),
        .v_y       (v_y),
        .v_z       (v_z),
        .t_x       (t_x),
        .t_y       (t_y),
        .t_z       (t_z),
        .dst_valid (sel_valid),
        .dst_stall (sel_stall),
        .dst_data  (sel_data)
    );

    rax_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (sel_valid),
        .src_stall (sel_stall),
        .src_data  (sel_data),
        .dst_valid (sq_valid),
        .dst_stall (sq_stall),
        .dst_data  (sq_data)
    );

    rax_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (sq_valid),
        .src_stall (sq_stall),
        .src_data  (sq_data),
        .dst_valid (rc_valid),
        .dst_stall (rc_stall),
        .dst_data  (rc_data)
    );

    rax_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .src_valid    (rc_valid),
        .src_stall    (rc_stall),
        .src_data     (rc_data),
        .dst_valid    (quat_valid),
        .dst_stall    (quat_stall),
        .quat_w       (quat_w),
        .quat_x       (quat_x),
        .quat_y       (quat_y),
        .quat_z       (quat_z),
        .branch_taken (branch_taken),
        .bad_input    (bad_input)
    );

endmodule

`default_nettype wire

/* src/rax_checker.sv */
// Port-level checks for rotation_axes_to_quaternion, bound to the top level.
// Uses rax_pkg.
`default_nettype none

module rax_assertions (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               quat_valid,
    input wire logic                               quat_stall,
    input wire logic signed [rax_pkg::FIELD_W-1:0] quat_w,
    input wire logic signed [rax_pkg::FIELD_W-1:0] quat_x,
    input wire logic [1:0]                         branch_taken,
    input wire logic                               bad_input
);

    // Held item stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && quat_stall |=> quat_valid && $stable(quat_w) && $stable(quat_x)
            && $stable(branch_taken) && $stable(bad_input))
        else $error("held item changed");

    // Trace case always has a positive radicand
    a_trace_ok: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && branch_taken == rax_pkg::BR_TRACE |-> !bad_input)
        else $error("trace case flagged bad");

    // Trace case: w is at least one half
    a_trace_w: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && branch_taken == rax_pkg::BR_TRACE |->
            !quat_w[rax_pkg::FIELD_W-1]
            && quat_w[rax_pkg::FIELD_W-2:0] >= (rax_pkg::FIELD_W-1)'(rax_pkg::HALF_ONE))
        else $error("trace case w below one half");

    // u branch: x comes from the root, never negative
    a_u_main: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && branch_taken == rax_pkg::BR_U |-> !quat_x[rax_pkg::FIELD_W-1])
        else $error("u branch x negative");

    // Nothing valid straight out of reset
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !quat_valid)
        else $error("valid item after reset");

endmodule

bind rotation_axes_to_quaternion rax_assertions u_rax_assertions (
    .clk          (clk),
    .rst_n        (rst_n),
    .quat_valid   (quat_valid),
    .quat_stall   (quat_stall),
    .quat_w       (quat_w),
    .quat_x       (quat_x),
    .branch_taken (branch_taken),
    .bad_input    (bad_input)
);

`default_nettype wire
